@@ rtl/hdg_pkg.sv @@
// shared types, codes and helpers for the hdg trace flux block
package hdg_pkg;

  localparam int MAX_COMPONENTS_DEF = 8;
  localparam int MAX_DIMS_DEF       = 3;
  localparam int MAX_TOTAL_DEF      = 32;

  localparam logic [2:0] OP_NORMAL    = 3'd0;
  localparam logic [2:0] OP_FLUX      = 3'd1;
  localparam logic [2:0] OP_FLUX_JAC  = 3'd2;
  localparam logic [2:0] OP_TAU       = 3'd3;
  localparam logic [2:0] OP_TAU_JAC   = 3'd4;
  localparam logic [2:0] OP_STATE     = 3'd5;
  localparam logic [2:0] OP_TRACE     = 3'd6;
  localparam logic [2:0] OP_COMPUTE   = 3'd7;

  localparam logic [1:0] KIND_FLUX  = 2'd0;
  localparam logic [1:0] KIND_STATE = 2'd1;
  localparam logic [1:0] KIND_TRACE = 2'd2;

  localparam logic [2:0] CFG_COMPONENT = 3'd0;
  localparam logic [2:0] CFG_GRADIENT  = 3'd1;
  localparam logic [2:0] CFG_TOTAL     = 3'd2;
  localparam logic [2:0] CFG_DIMENSION = 3'd3;
  localparam logic [2:0] CFG_MODE      = 3'd4;
  localparam logic [2:0] CFG_JACOBIAN  = 3'd5;

  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

  // term groups of one result, walked in this order
  typedef enum logic [2:0] {
    GRP_JAC, GRP_TPLUS, GRP_TMINUS, GRP_TJAC, GRP_FLUX, GRP_TDIFF
  } grp_t;

  typedef struct packed {
    logic              we;
    logic [2:0]        op;
    logic [4:0]        col;
    logic [2:0]        row;
    logic [2:0]        inner;
    logic signed [31:0] val;
  } load_t;

  typedef struct packed {
    logic       valid;
    logic       mark;
    grp_t       grp;
    logic [4:0] k;
    logic [3:0] idx;
    logic [2:0] row;
  } issue_t;

  typedef struct packed {
    logic               valid;
    logic               mark;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } operand_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -64'sh0000_0000_8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

@@ rtl/hdg_store.sv @@
// point stores with registered reads and operand selection
module hdg_store #(
  parameter int MAX_COMPONENTS = hdg_pkg::MAX_COMPONENTS_DEF,
  parameter int MAX_DIMS       = hdg_pkg::MAX_DIMS_DEF,
  parameter int MAX_TOTAL      = hdg_pkg::MAX_TOTAL_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  hdg_pkg::load_t    load,
  input  hdg_pkg::issue_t   iss,
  output hdg_pkg::operand_t opnd
);
  import hdg_pkg::*;

  localparam int NRM_D = MAX_DIMS;
  localparam int FLX_D = MAX_DIMS * MAX_COMPONENTS;
  localparam int FJ_D  = MAX_TOTAL * MAX_DIMS * MAX_COMPONENTS;
  localparam int TAU_D = MAX_COMPONENTS * MAX_COMPONENTS;
  localparam int TJ_D  = MAX_COMPONENTS * MAX_COMPONENTS * MAX_COMPONENTS;
  localparam int ST_D  = MAX_TOTAL;
  localparam int TR_D  = MAX_COMPONENTS;
  localparam int NRM_AW = (NRM_D > 1) ? $clog2(NRM_D) : 1;
  localparam int FLX_AW = (FLX_D > 1) ? $clog2(FLX_D) : 1;
  localparam int FJ_AW  = (FJ_D > 1) ? $clog2(FJ_D) : 1;
  localparam int TAU_AW = (TAU_D > 1) ? $clog2(TAU_D) : 1;
  localparam int TJ_AW  = (TJ_D > 1) ? $clog2(TJ_D) : 1;
  localparam int ST_AW  = (ST_D > 1) ? $clog2(ST_D) : 1;
  localparam int TR_AW  = (TR_D > 1) ? $clog2(TR_D) : 1;

  logic signed [31:0] normal_mem [NRM_D];
  logic signed [31:0] flux_mem   [FLX_D];
  logic signed [31:0] fj_mem     [FJ_D];
  logic signed [31:0] tau_mem    [TAU_D];
  logic signed [31:0] tj_mem     [TJ_D];
  logic signed [31:0] state_mem  [ST_D];
  logic signed [31:0] trace_mem  [TR_D];

  logic col_tot, col_cmp, row_cmp, inner_dim, inner_cmp;
  logic [NRM_AW-1:0] w_nrm, r_nrm;
  logic [FLX_AW-1:0] w_flx, r_flx;
  logic [FJ_AW-1:0]  w_fj, r_fj;
  logic [TAU_AW-1:0] w_tau, r_tau;
  logic [TJ_AW-1:0]  w_tj, r_tj;
  logic [ST_AW-1:0]  w_st, r_st;
  logic [TR_AW-1:0]  w_tr, r_tr;
  logic [4:0] tcol;

  logic signed [31:0] rd_normal, rd_flux, rd_fj, rd_tau, rd_tj, rd_state, rd_trace;
  logic rd_valid, rd_mark;
  grp_t rd_grp;

  logic signed [32:0] diff_wide;
  logic signed [31:0] diff, a_sel, b_sel;

  always_comb begin
    col_tot   = int'(load.col) < MAX_TOTAL;
    col_cmp   = int'(load.col) < MAX_COMPONENTS;
    row_cmp   = int'(load.row) < MAX_COMPONENTS;
    inner_dim = int'(load.inner) < MAX_DIMS;
    inner_cmp = int'(load.inner) < MAX_COMPONENTS;
    w_nrm = NRM_AW'(int'(load.inner));
    w_flx = FLX_AW'(int'(load.inner) * MAX_COMPONENTS + int'(load.row));
    w_fj  = FJ_AW'((int'(load.col) * MAX_DIMS + int'(load.inner)) * MAX_COMPONENTS
                   + int'(load.row));
    w_tau = TAU_AW'(int'(load.col) * MAX_COMPONENTS + int'(load.row));
    w_tj  = TJ_AW'((int'(load.col) * MAX_COMPONENTS + int'(load.inner)) * MAX_COMPONENTS
                   + int'(load.row));
    w_st  = ST_AW'(int'(load.col));
    w_tr  = TR_AW'(int'(load.col));
    tcol  = (iss.grp == GRP_TDIFF) ? 5'(iss.idx) : iss.k;
    r_nrm = NRM_AW'(int'(iss.idx));
    r_flx = FLX_AW'(int'(iss.idx) * MAX_COMPONENTS + int'(iss.row));
    r_fj  = FJ_AW'((int'(iss.k) * MAX_DIMS + int'(iss.idx)) * MAX_COMPONENTS
                   + int'(iss.row));
    r_tau = TAU_AW'(int'(tcol) * MAX_COMPONENTS + int'(iss.row));
    r_tj  = TJ_AW'((int'(iss.k) * MAX_COMPONENTS + int'(iss.idx)) * MAX_COMPONENTS
                   + int'(iss.row));
    r_st  = ST_AW'(int'(iss.idx));
    r_tr  = TR_AW'(int'(iss.idx));
  end

  always_ff @(posedge clk) begin
    if (load.we) begin
      case (load.op)
        OP_NORMAL:   if (inner_dim) normal_mem[w_nrm] <= load.val;
        OP_FLUX:     if (inner_dim && row_cmp) flux_mem[w_flx] <= load.val;
        OP_FLUX_JAC: if (col_tot && inner_dim && row_cmp) fj_mem[w_fj] <= load.val;
        OP_TAU:      if (col_cmp && row_cmp) tau_mem[w_tau] <= load.val;
        OP_TAU_JAC:  if (col_cmp && inner_cmp && row_cmp) tj_mem[w_tj] <= load.val;
        OP_STATE:    if (col_tot) state_mem[w_st] <= load.val;
        OP_TRACE:    if (col_cmp) trace_mem[w_tr] <= load.val;
        default: ;
      endcase
    end
    rd_normal <= normal_mem[r_nrm];
    rd_flux   <= flux_mem[r_flx];
    rd_fj     <= fj_mem[r_fj];
    rd_tau    <= tau_mem[r_tau];
    rd_tj     <= tj_mem[r_tj];
    rd_state  <= state_mem[r_st];
    rd_trace  <= trace_mem[r_tr];
    rd_grp    <= iss.grp;
    rd_mark   <= iss.mark;
  end

  always_comb begin
    diff_wide = {rd_state[31], rd_state} - {rd_trace[31], rd_trace};
    if (diff_wide[32] != diff_wide[31]) diff = diff_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else diff = diff_wide[31:0];
    case (rd_grp)
      GRP_FLUX: begin
        a_sel = rd_flux;
        b_sel = rd_normal;
      end
      GRP_JAC: begin
        a_sel = rd_fj;
        b_sel = rd_normal;
      end
      GRP_TDIFF: begin
        a_sel = rd_tau;
        b_sel = diff;
      end
      GRP_TJAC: begin
        a_sel = rd_tj;
        b_sel = diff;
      end
      GRP_TPLUS: begin
        a_sel = rd_tau;
        b_sel = Q_ONE;
      end
      GRP_TMINUS: begin
        a_sel = rd_tau;
        b_sel = -Q_ONE;
      end
      default: begin
        a_sel = '0;
        b_sel = '0;
      end
    endcase
    if (rd_mark) b_sel = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid   <= 1'b0;
      opnd.valid <= 1'b0;
    end else begin
      rd_valid   <= iss.valid;
      opnd.valid <= rd_valid;
    end
    opnd.mark <= rd_mark;
    opnd.a    <= a_sel;
    opnd.b    <= b_sel;
  end

endmodule

@@ rtl/hdg_mac.sv @@
// q16.16 multiply and 64-bit accumulate with saturated result
module hdg_mac (
  input  logic               clk,
  input  logic               rst,
  input  hdg_pkg::operand_t  opnd,
  output logic               done,
  output logic signed [31:0] value
);
  import hdg_pkg::*;

  logic signed [63:0] prod;
  logic signed [63:0] acc;
  logic signed [63:0] sum;
  logic p_valid, p_mark;

  assign sum = acc + (prod >>> 16);

  always_ff @(posedge clk) begin
    prod <= opnd.a * opnd.b;
    p_mark <= opnd.mark;
    if (rst) begin
      p_valid <= 1'b0;
      done    <= 1'b0;
      acc     <= '0;
    end else begin
      p_valid <= opnd.valid;
      done    <= p_valid && p_mark;
      if (p_valid) begin
        if (p_mark) begin
          acc   <= '0;
          value <= sat32(sum);
        end else begin
          acc <= sum;
        end
      end
    end
  end

endmodule

@@ rtl/hdg_trace_flux_normal.sv @@
// Normal trace flux of a hybridized DG face for one quadrature point. Load items
// (normal, flux, flux Jacobian, tau, tau Jacobian, state, trace) are written one per
// cycle while the block is idle. A compute item for a row walks every result term
// by term through the point memories, one term per cycle into a read, operand,
// multiply and accumulate pipeline; each result passes a hold step, which waits
// while the output is stalled, then six group steps, then drains the pipeline.
// Inputs are stalled while a row is being worked; configuration is to be written by
// the user only when the block is idle, as the block itself does not enforce it.
module hdg_trace_flux_normal #(
  parameter int MAX_COMPONENTS = hdg_pkg::MAX_COMPONENTS_DEF,
  parameter int MAX_DIMS       = hdg_pkg::MAX_DIMS_DEF,
  parameter int MAX_TOTAL      = hdg_pkg::MAX_TOTAL_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [5:0]         cfg_data,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [2:0]         operation,
  input  logic [4:0]         column_index,
  input  logic [2:0]         row_index,
  input  logic [2:0]         inner_index,
  input  logic signed [31:0] element_value,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [1:0]         result_kind,
  output logic [2:0]         result_row,
  output logic [4:0]         result_column,
  output logic signed [31:0] result_value,
  output logic               last_of_row
);
  import hdg_pkg::*;

  localparam logic [1:0] MODE_TRACE = 2'd0;
  localparam logic [1:0] MODE_IFACE = 2'd1;
  localparam logic [1:0] MODE_PURE  = 2'd2;

  typedef enum logic [1:0] {ST_IDLE, ST_HOLD, ST_ISSUE, ST_WAIT} state_t;

  logic [3:0] comp_cnt;
  logic [4:0] grad_cnt;
  logic [5:0] total_cnt;
  logic [1:0] dim_cnt;
  logic [1:0] mode_reg;
  logic       jac_en;

  logic [3:0] ncu;
  logic [1:0] nd;
  logic [5:0] nc, ncq, ncols;
  logic [6:0] sum_q;
  logic [1:0] mode;

  state_t     state;
  logic [1:0] kind;
  logic [4:0] k;
  logic [2:0] row;
  grp_t       grp;
  logic [3:0] idx;
  logic       last_res;

  logic       grp_en, do_term, at_end, accept, k_low;
  logic [3:0] grp_cnt;
  logic [1:0] kind_next;
  logic [4:0] k_next;
  logic       last_next;

  load_t      load;
  issue_t     iss;
  operand_t   opnd;
  logic       mac_done;
  logic signed [31:0] mac_value;

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      comp_cnt  <= 4'd1;
      grad_cnt  <= 5'd0;
      total_cnt <= 6'd1;
      dim_cnt   <= 2'd1;
      mode_reg  <= 2'd0;
      jac_en    <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_COMPONENT: comp_cnt  <= cfg_data[3:0];
        CFG_GRADIENT:  grad_cnt  <= cfg_data[4:0];
        CFG_TOTAL:     total_cnt <= cfg_data;
        CFG_DIMENSION: dim_cnt   <= cfg_data[1:0];
        CFG_MODE:      mode_reg  <= cfg_data[1:0];
        CFG_JACOBIAN:  jac_en    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ncu   = (int'(comp_cnt) > MAX_COMPONENTS) ? 4'(MAX_COMPONENTS) : comp_cnt;
    nd    = (int'(dim_cnt) > MAX_DIMS) ? 2'(MAX_DIMS) : dim_cnt;
    nc    = (int'(total_cnt) > MAX_TOTAL) ? 6'(MAX_TOTAL) : total_cnt;
    ncq   = (int'(grad_cnt) > MAX_TOTAL) ? 6'(MAX_TOTAL) : {1'b0, grad_cnt};
    mode  = (mode_reg >= MODE_PURE) ? MODE_PURE : mode_reg;
    sum_q = 7'(ncu) + 7'(ncq);
    if (mode == MODE_TRACE) ncols = (int'(sum_q) > MAX_TOTAL) ? 6'(MAX_TOTAL) : sum_q[5:0];
    else ncols = nc;
    k_low = 6'(k) < 6'(ncu);

    case (grp)
      GRP_JAC: begin
        grp_en  = (kind == KIND_STATE && !(mode == MODE_TRACE && k_low)) ||
                  (kind == KIND_TRACE && mode == MODE_TRACE);
        grp_cnt = 4'(nd);
      end
      GRP_TPLUS: begin
        grp_en  = kind == KIND_STATE && k_low && mode != MODE_PURE;
        grp_cnt = 4'd1;
      end
      GRP_TMINUS: begin
        grp_en  = kind == KIND_TRACE && mode != MODE_PURE;
        grp_cnt = 4'd1;
      end
      GRP_TJAC: begin
        grp_en  = kind == KIND_TRACE && mode != MODE_PURE;
        grp_cnt = ncu;
      end
      GRP_FLUX: begin
        grp_en  = kind == KIND_FLUX;
        grp_cnt = 4'(nd);
      end
      GRP_TDIFF: begin
        grp_en  = kind == KIND_FLUX && mode != MODE_PURE;
        grp_cnt = ncu;
      end
      default: begin
        grp_en  = 1'b0;
        grp_cnt = 4'd0;
      end
    endcase
    do_term = (state == ST_ISSUE) && grp_en && (idx < grp_cnt);
    at_end  = (state == ST_ISSUE) && !do_term && (grp == GRP_TDIFF);

    case (kind)
      KIND_FLUX: begin
        kind_next = (ncols != 6'd0) ? KIND_STATE : KIND_TRACE;
        k_next    = 5'd0;
      end
      KIND_STATE: begin
        kind_next = (6'(k) + 6'd1 < ncols) ? KIND_STATE : KIND_TRACE;
        k_next    = (6'(k) + 6'd1 < ncols) ? k + 5'd1 : 5'd0;
      end
      default: begin
        kind_next = KIND_TRACE;
        k_next    = k + 5'd1;
      end
    endcase
    last_next = (kind_next == KIND_TRACE) && (6'(k_next) + 6'd1 == 6'(ncu));

    load.we    = accept && operation != OP_COMPUTE;
    load.op    = operation;
    load.col   = column_index;
    load.row   = row_index;
    load.inner = inner_index;
    load.val   = element_value;

    iss.valid = do_term || at_end;
    iss.mark  = at_end;
    iss.grp   = grp;
    iss.k     = k;
    iss.idx   = idx;
    iss.row   = row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) result_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept && operation == OP_COMPUTE && 4'(row_index) < ncu) begin
            row      <= row_index;
            kind     <= KIND_FLUX;
            k        <= 5'd0;
            last_res <= !jac_en;
            grp      <= GRP_JAC;
            idx      <= 4'd0;
            state    <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (!result_valid || !result_stall) state <= ST_ISSUE;
        end
        ST_ISSUE: begin
          if (do_term) begin
            idx <= idx + 4'd1;
          end else if (at_end) begin
            state <= ST_WAIT;
          end else begin
            grp <= grp_t'(grp + 3'd1);
            idx <= 4'd0;
          end
        end
        ST_WAIT: begin
          if (mac_done) begin
            result_valid  <= 1'b1;
            result_kind   <= kind;
            result_row    <= row;
            result_column <= (kind == KIND_FLUX) ? 5'd0 : k;
            result_value  <= mac_value;
            last_of_row   <= last_res;
            if (last_res) begin
              state <= ST_IDLE;
            end else begin
              kind     <= kind_next;
              k        <= k_next;
              last_res <= last_next;
              grp      <= GRP_JAC;
              idx      <= 4'd0;
              state    <= ST_HOLD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  hdg_store #(
    .MAX_COMPONENTS(MAX_COMPONENTS),
    .MAX_DIMS      (MAX_DIMS),
    .MAX_TOTAL     (MAX_TOTAL)
  ) u_store (
    .clk (clk),
    .rst (rst),
    .load(load),
    .iss (iss),
    .opnd(opnd)
  );

  hdg_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .opnd (opnd),
    .done (mac_done),
    .value(mac_value)
  );

endmodule
